// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files, included by the decoder core.
// Each macro takes a label, clock, active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/ctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_pkg
// Types, constants and byte classifiers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int SIZE_WIDTH_DEF = 32;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_HT    = 8'h09;

    // bytes dropped after each chunk payload (CR LF, unchecked)
    localparam int TRAIL_BYTES = 2;

    typedef enum logic {
        ST_SIZE_LINE = 1'b0,
        ST_DATA      = 1'b1
    } t_stage;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       segment_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       chunk_end;
        logic       size_overflow;
    } t_out_beat;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // ASCII hex digit decode, either case
    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h57);
        end
        return h;
    endfunction

    // space, HT, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b >= BYTE_HT && b <= BYTE_CR);
    endfunction

endpackage

// ===== design/chunked_transfer_decoder_core.sv =====
// Throughput: one input beat per cycle while the skid register is empty;
// size-line and trailer beats give no output beat. A two-entry output stage
// (result register plus skid register) takes one more payload beat while the
// output stalls; input stalls only while the skid register is full.
// Reset (synchronous, active low) returns to the size-line stage, clears the size,
// the byte count, the sticky overflow flag and both output valids.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_core
// Byte-serial HTTP chunked body decoder: parses hex size lines, passes the
// payload bytes through and drops the CR LF after each chunk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_transfer_decoder_core
    import ctd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input beats
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    output logic      o_in_stall,
    // output beats
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    localparam int CNT_WIDTH = SIZE_WIDTH + 1;

    // parser state
    t_stage                r_stage,          n_stage;
    logic [SIZE_WIDTH-1:0] r_size_accum,     n_size_accum;
    logic                  r_digits_stopped, n_digits_stopped;
    logic                  r_line_started,   n_line_started;
    logic                  r_prev_was_cr,    n_prev_was_cr;
    logic [CNT_WIDTH-1:0]  r_bytes_left,     n_bytes_left;
    logic                  r_overflow_seen,  n_overflow_seen;

    // output stage
    logic      r_out_valid,  n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_beat r_out_beat,   n_out_beat;
    t_out_beat r_skid_beat,  n_skid_beat;

    logic       in_accept;
    logic       out_fire;
    logic       res_valid;
    t_out_beat  res_beat;
    logic [7:0] b;
    t_hex       hex;
    logic       size_sat;
    logic       line_end;

    assign b          = i_in_beat.in_byte;
    assign hex        = hex_decode(b);
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_fire   = r_out_valid && !i_out_stall;
    assign size_sat   = |r_size_accum[SIZE_WIDTH-1 -: 4];
    assign line_end   = r_prev_was_cr && (b == BYTE_LF);

    // parser: next state and result beat
    always_comb begin
        n_stage          = r_stage;
        n_size_accum     = r_size_accum;
        n_digits_stopped = r_digits_stopped;
        n_line_started   = r_line_started;
        n_prev_was_cr    = r_prev_was_cr;
        n_bytes_left     = r_bytes_left;
        n_overflow_seen  = r_overflow_seen;
        res_valid        = 1'b0;
        res_beat.body_byte     = b;
        res_beat.chunk_end     = (r_bytes_left == CNT_WIDTH'(TRAIL_BYTES + 1));
        res_beat.size_overflow = r_overflow_seen;

        if (in_accept) begin
            case (r_stage)
                ST_DATA: begin
                    // payload while more than the trailer remains
                    res_valid = (r_bytes_left > CNT_WIDTH'(TRAIL_BYTES));
                    if (r_bytes_left != '0) begin
                        n_bytes_left = r_bytes_left - CNT_WIDTH'(1);
                    end
                    if (r_bytes_left <= CNT_WIDTH'(1)) begin
                        n_stage          = ST_SIZE_LINE;
                        n_size_accum     = '0;
                        n_digits_stopped = 1'b0;
                        n_line_started   = 1'b0;
                        n_prev_was_cr    = 1'b0;
                    end
                end
                ST_SIZE_LINE: begin
                    if (line_end) begin
                        // CR LF: payload plus trailer
                        n_bytes_left = CNT_WIDTH'(r_size_accum) + CNT_WIDTH'(TRAIL_BYTES);
                        n_stage          = ST_DATA;
                        n_size_accum     = '0;
                        n_digits_stopped = 1'b0;
                        n_line_started   = 1'b0;
                        n_prev_was_cr    = 1'b0;
                    end else begin
                        n_prev_was_cr = (b == BYTE_CR);
                        if (!r_digits_stopped) begin
                            if (!r_line_started && is_blank(b)) begin
                                // leading blank, skipped
                            end else if (hex.ok) begin
                                n_line_started = 1'b1;
                                if (size_sat) begin
                                    n_size_accum    = '1;
                                    n_overflow_seen = 1'b1;
                                end else begin
                                    n_size_accum = {r_size_accum[SIZE_WIDTH-5:0], hex.val};
                                end
                            end else begin
                                n_line_started   = 1'b1;
                                n_digits_stopped = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_stage = ST_SIZE_LINE;
                end
            endcase
        end
    end

    // output stage: result register with skid register behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_beat   = r_out_beat;
        n_skid_beat  = r_skid_beat;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out_beat   = r_skid_beat;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                n_out_beat  = res_beat;
                n_out_valid = 1'b1;
            end else begin
                n_skid_beat  = res_beat;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage          <= ST_SIZE_LINE;
            r_size_accum     <= '0;
            r_digits_stopped <= 1'b0;
            r_line_started   <= 1'b0;
            r_prev_was_cr    <= 1'b0;
            r_bytes_left     <= '0;
            r_overflow_seen  <= 1'b0;
            r_out_valid      <= 1'b0;
            r_skid_valid     <= 1'b0;
        end else begin
            r_stage          <= n_stage;
            r_size_accum     <= n_size_accum;
            r_digits_stopped <= n_digits_stopped;
            r_line_started   <= n_line_started;
            r_prev_was_cr    <= n_prev_was_cr;
            r_bytes_left     <= n_bytes_left;
            r_overflow_seen  <= n_overflow_seen;
            r_out_valid      <= n_out_valid;
            r_skid_valid     <= n_skid_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_beat  <= n_out_beat;
        r_skid_beat <= n_skid_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // checks
    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_IMPL(a_data_count_live, i_clk, i_rst_n, r_stage == ST_DATA, r_bytes_left != '0)
    `ASSERT_NEXT(a_overflow_sticky, i_clk, i_rst_n, r_overflow_seen, r_overflow_seen)
    `ASSERT_NEXT(a_line_end_clears, i_clk, i_rst_n, in_accept && r_stage == ST_SIZE_LINE && line_end, r_stage == ST_DATA && r_size_accum == '0)

endmodule

// ===== bench/chunked_transfer_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_core_tb
// Streams chunked bodies (clean chunks, odd size lines, garbage lines, bad
// trailers and one oversized chunk at the end) through the decoder byte by
// byte, predicts every payload beat and compares it field by field.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_core_tb
    import ctd_pkg::*;
();

    localparam int SIZE_W     = SIZE_WIDTH_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int RAND_BEATS = 340;
    localparam int MAX_PRINTS = 20;

    // ------------------------------------------------------------------
    // Decoder prediction and expected payload beats
    // ------------------------------------------------------------------
    class chunk_scoreboard;
        t_stage            stage;
        logic [SIZE_W-1:0] size_acc;
        logic              digits_done;
        logic              line_begun;
        logic              last_cr;
        logic              ovf_sticky;
        logic [SIZE_W:0]   left;
        t_out_beat         payload_q[$];
        int unsigned       errors;

        function new();
            stage      = ST_SIZE_LINE;
            left       = '0;
            ovf_sticky = 1'b0;
            errors     = 0;
            new_line();
        endfunction

        function void new_line();
            size_acc    = '0;
            digits_done = 1'b0;
            line_begun  = 1'b0;
            last_cr     = 1'b0;
        endfunction

        function int pending();
            return payload_q.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // advance the decoder by one accepted input beat
        function void note_beat(input t_in_beat b);
            logic [7:0] c;
            logic       is_hex;
            logic [3:0] nib;
            t_out_beat  r;
            c = b.in_byte;
            if (stage == ST_DATA) begin
                if (left > (SIZE_W+1)'(TRAIL_BYTES)) begin
                    r.body_byte     = c;
                    r.chunk_end     = (left == (SIZE_W+1)'(TRAIL_BYTES + 1));
                    r.size_overflow = ovf_sticky;
                    payload_q.push_back(r);
                end
                if (left != 0) left--;
                if (left == 0) begin
                    stage = ST_SIZE_LINE;
                    new_line();
                end
            end else if (last_cr && c == BYTE_LF) begin
                // line end: payload plus the unchecked trailer pair
                left  = {1'b0, size_acc} + (SIZE_W+1)'(TRAIL_BYTES);
                stage = ST_DATA;
                new_line();
            end else begin
                last_cr = (c == BYTE_CR);
                is_hex  = 1'b1;
                nib     = '0;
                if (c >= 8'h30 && c <= 8'h39)      nib = c[3:0];
                else if (c >= 8'h41 && c <= 8'h46) nib = c[3:0] + 4'd9;
                else if (c >= 8'h61 && c <= 8'h66) nib = c[3:0] + 4'd9;
                else                               is_hex = 1'b0;
                if (!digits_done) begin
                    if (!line_begun && (c == 8'h20 || (c >= 8'h09 && c <= BYTE_CR))) begin
                        // leading blank, skipped
                    end else if (is_hex) begin
                        line_begun = 1'b1;
                        if (size_acc[SIZE_W-1 -: 4] != 4'd0) begin
                            size_acc   = '1;
                            ovf_sticky = 1'b1;
                        end else begin
                            size_acc = {size_acc[SIZE_W-5:0], nib};
                        end
                    end else begin
                        line_begun  = 1'b1;
                        digits_done = 1'b1;
                    end
                end
            end
        endfunction

        task check_beat(input t_out_beat got);
            t_out_beat want;
            if (payload_q.size() == 0) begin
                report($sformatf("unexpected beat byte=%02h", got.body_byte));
            end else begin
                want = payload_q.pop_front();
                if (got.body_byte !== want.body_byte)
                    report($sformatf("body_byte %02h, want %02h", got.body_byte,
                                     want.body_byte));
                if (got.chunk_end !== want.chunk_end)
                    report($sformatf("chunk_end %b, want %b (byte %02h)", got.chunk_end,
                                     want.chunk_end, want.body_byte));
                if (got.size_overflow !== want.size_overflow)
                    report($sformatf("size_overflow %b, want %b", got.size_overflow,
                                     want.size_overflow));
            end
        endtask

        task flush_leftovers();
            while (payload_q.size() != 0) begin
                report($sformatf("missing beat byte=%02h", payload_q[0].body_byte));
                void'(payload_q.pop_front());
            end
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    chunk_scoreboard board = new();

    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned chunks_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    logic [31:0] stall_cyc = '0;

    string crlf        = "\015\012";
    string lead_blanks = " \011\012\013\014";
    string noise_lead  = "xX-+;gz";

    chunked_transfer_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall pattern: free, light random, periodic, heavy random
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 32'd1;
        case (stall_cyc[8:7])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2'd2: i_out_stall <= (stall_cyc[2:0] < 3'd3);
            default: i_out_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_beat(o_out_beat);
            beats_out++;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // One input beat; bursts of random length, most separated by random gaps
    task automatic send_beat(input logic [7:0] c);
        t_in_beat b;
        b.in_byte     = c;
        b.segment_end = 1'($urandom_range(0, 1));
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        board.note_beat(b);
        beats_in++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_beat(s[k]);
    endtask

    // Hold the sender off until every expected beat is out
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // One chunk: size line of a random flavor, payload, trailer pair
    task automatic send_random_chunk();
        int unsigned kind;
        int unsigned pick;
        int unsigned sz;
        logic [7:0]  junk;
        string       digits;
        kind   = $urandom_range(0, 99);
        pick   = $urandom_range(0, 19);
        sz     = (pick < 14) ? $urandom_range(0, 8) :
                 (pick < 19) ? $urandom_range(9, 48) : $urandom_range(49, 300);
        digits = $sformatf("%0h", sz);
        if ($urandom_range(0, 1)) digits = digits.toupper();
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 2))
            digits = {"0", digits};

        // leading blanks; a CR only right before the first real byte
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) send_beat(lead_blanks[$urandom_range(0, 4)]);
            if ($urandom_range(0, 3) == 0) send_beat(BYTE_CR);
        end

        if (kind < 75) begin
            // clean size line, sometimes with an extension
            send_text(digits);
            if ($urandom_range(0, 2) == 0) begin
                send_beat(8'h3B);
                repeat ($urandom_range(0, 6)) send_beat(8'($urandom_range(8'h21, 8'h7E)));
            end
        end else if (kind < 87) begin
            // garbage line, no digits first
            sz = 0;
            send_beat(noise_lead[$urandom_range(0, 6)]);
            repeat ($urandom_range(0, 6)) begin
                junk = 8'($urandom_range(0, 255));
                send_beat((junk == BYTE_LF || junk == BYTE_CR) ? 8'h7F : junk);
            end
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    // 0x prefix stops after the leading zero
                    send_text("0x");
                    send_text(digits);
                    sz = 0;
                end
                1: begin
                    send_beat($urandom_range(0, 1) ? 8'h2D : 8'h2B);
                    send_text(digits);
                    sz = 0;
                end
                2: begin
                    // stray CR not followed by LF
                    send_text(digits);
                    send_beat(BYTE_CR);
                    send_beat(8'h39);
                end
                3: sz = 0;
                default: begin
                    send_text(digits);
                    send_text(" 5");
                end
            endcase
        end

        send_text(crlf);
        repeat (sz) send_beat(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            send_beat(8'($urandom_range(0, 255)));
            send_beat(8'($urandom_range(0, 255)));
        end else begin
            send_text(crlf);
        end
        chunks_sent++;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero chunk, all leading blanks with payload extremes, 0x prefix
        // with a junk trailer
        send_text("0\015\012\015\012");
        send_text(" \011\012\013\014\0152\015\012");
        send_beat(8'h00);
        send_beat(8'hFF);
        send_text(crlf);
        send_text("0x1A\015\012xy");
        chunks_sent += 3;
        wait_for_results();

        while (beats_in < RAND_BEATS) begin
            send_random_chunk();
            if ($urandom_range(0, 11) == 0) wait_for_results();
        end
        wait_for_results();

        // oversized size saturates; its payload never ends, so it goes last
        send_text("1FFFFFFFF;big\015\012");
        repeat (40) send_beat(8'($urandom_range(0, 255)));
        chunks_sent++;
        wait_for_results();
        repeat (8) @(posedge i_clk);
        board.flush_leftovers();

        $display("Sent %0d bytes in %0d chunks, checked %0d payload beats,", beats_in,
                 chunks_sent, beats_out);
        $display("including an oversized chunk with the sticky overflow flag; %0d errors",
                 board.errors);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
